// ===== hdl/kvt_pkg.sv =====
// shared constants and request codes for the key/value table
package kvt_pkg;

   // fixed widths of the channel fields
   localparam int KEY_PORT_W   = 32;
   localparam int VALUE_PORT_W = 32;
   localparam int KIND_W       = 3;
   localparam int RANK_W       = 8;
   localparam int CAP_W        = 9;
   localparam int COUNT_OUT_W  = 9;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UPSERT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RANK   = 3'd5;

endpackage

// ===== hdl/kvt_if.sv =====
// request, response and control-register channels of the key/value table

interface kvt_req_if;
   logic                               valid;
   logic                               ready;
   logic [kvt_pkg::KIND_W-1:0]         kind;
   logic [kvt_pkg::KEY_PORT_W-1:0]     req_key;
   logic [kvt_pkg::VALUE_PORT_W-1:0]   req_value;
   logic [kvt_pkg::RANK_W-1:0]         rank_index;

   modport source (output valid, kind, req_key, req_value, rank_index, input ready);
   modport sink   (input valid, kind, req_key, req_value, rank_index, output ready);
endinterface

interface kvt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               ok;
   logic [kvt_pkg::KEY_PORT_W-1:0]     found_key;
   logic [kvt_pkg::VALUE_PORT_W-1:0]   found_value;
   logic [kvt_pkg::COUNT_OUT_W-1:0]    entry_count;
   logic                               is_empty;

   modport source (output valid, ok, found_key, found_value, entry_count, is_empty,
                   input ready);
   modport sink   (input valid, ok, found_key, found_value, entry_count, is_empty,
                   output ready);
endinterface

interface kvt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [kvt_pkg::CAP_W-1:0]          data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/kvt_store.sv =====
// key and value memories: one write port, one registered read port
module kvt_store #(
   parameter int DEPTH      = 256,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [KEY_BITS-1:0]                   wr_key,
   input  logic [VALUE_BITS-1:0]                 wr_value,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [KEY_BITS-1:0]                   rd_key,
   output logic [VALUE_BITS-1:0]                 rd_value
);
   logic [KEY_BITS-1:0]   key_mem   [DEPTH];
   logic [VALUE_BITS-1:0] value_mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
   end
endmodule

// ===== hdl/key_value_table_with_rank_unit.sv =====
// Key/value table top level: unsorted store with search, erase and rank query.
// One request at a time. Insert, update, upsert, erase and lookup scan the stored
// pairs through the single memory read port, one entry per cycle.
// A rank query scans the whole table once per candidate.
// The response sits in an output register, so the next request may start while it waits.
// Reset (synchronous) empties the table and sets capacity to 256; memories are not cleared.
module key_value_table_with_rank_unit #(
   parameter int DEPTH      = 256,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   kvt_req_if.sink            req,
   kvt_rsp_if.source          rsp,
   kvt_csr_if.sink            csr
);
   import kvt_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_ERASE_RD, ST_ERASE_WR,
      ST_RANK_OUT, ST_RANK_CAND, ST_RANK_IN, ST_REPLY
   } state_type;

   state_type              state_ff, state_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [RANK_W-1:0]      rank_ff, rank_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [CW-1:0]          issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          pend_idx_ff, pend_idx_in;
   logic                   hit_ff, hit_in;
   logic [AW-1:0]          slot_ff, slot_in;
   logic [KEY_BITS-1:0]    cand_key_ff, cand_key_in;
   logic [VALUE_BITS-1:0]  cand_val_ff, cand_val_in;
   logic [CW-1:0]          smaller_ff, smaller_in;
   logic [CW-1:0]          outer_ff, outer_in;
   logic                   ok_ff, ok_in;
   logic [KEY_BITS-1:0]    fkey_ff, fkey_in;
   logic [VALUE_BITS-1:0]  fval_ff, fval_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [KEY_PORT_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [VALUE_PORT_W-1:0] rsp_val_ff, rsp_val_in;
   logic [COUNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [KEY_BITS-1:0]    wr_key;
   logic [VALUE_BITS-1:0]  wr_value;
   logic [AW-1:0]          rd_addr;
   logic [KEY_BITS-1:0]    rd_key;
   logic [VALUE_BITS-1:0]  rd_value;

   logic [63:0]            req_key_wide;
   logic [63:0]            req_val_wide;
   logic [63:0]            fkey_wide;
   logic [63:0]            fval_wide;
   logic [CW-1:0]          last_idx;
   logic                   room;
   logic                   key_match;

   kvt_store #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_value (wr_value),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   // field width adaption
   assign req_key_wide = 64'(req.req_key);
   assign req_val_wide = 64'(req.req_value);
   assign fkey_wide    = 64'(fkey_ff);
   assign fval_wide    = 64'(fval_ff);

   // helpers
   assign last_idx  = count_ff - CW'(1);
   assign room      = (MW'(count_ff) < MW'(cap_ff)) && (count_ff < CW'(DEPTH));
   assign key_match = pend_ff && (rd_key == key_ff);

   // handshakes and response port
   assign req.ready       = (state_ff == ST_IDLE);
   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ok          = rsp_ok_ff;
   assign rsp.found_key   = rsp_key_ff;
   assign rsp.found_value = rsp_val_ff;
   assign rsp.entry_count = rsp_cnt_ff;
   assign rsp.is_empty    = rsp_empty_ff;

   // read address selection
   always_comb begin
      case (state_ff)
         ST_ERASE_RD: rd_addr = last_idx[AW-1:0];
         ST_RANK_OUT: rd_addr = outer_ff[AW-1:0];
         default:     rd_addr = issue_ff[AW-1:0];
      endcase
   end

   // sequencer next state and memory write
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      rank_in      = rank_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      cand_key_in  = cand_key_ff;
      cand_val_in  = cand_val_ff;
      smaller_in   = smaller_ff;
      outer_in     = outer_ff;
      ok_in        = ok_ff;
      fkey_in      = fkey_ff;
      fval_in      = fval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_empty_in = rsp_empty_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_key       = key_ff;
      wr_value     = value_ff;

      // control register write
      if (csr.valid) begin
         cap_in = csr.data;
      end

      // response transfer
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               kind_in  = req.kind;
               key_in   = req_key_wide[KEY_BITS-1:0];
               value_in = req_val_wide[VALUE_BITS-1:0];
               rank_in  = req.rank_index;
               ok_in    = 1'b0;
               fkey_in  = req_key_wide[KEY_BITS-1:0];
               fval_in  = '0;
               issue_in = '0;
               pend_in  = 1'b0;
               outer_in = '0;
               if (req.kind == KIND_RANK) begin
                  if (MW'(req.rank_index) < MW'(count_ff)) begin
                     state_in = ST_RANK_OUT;
                  end else begin
                     state_in = ST_REPLY;
                  end
               end else if (req.kind inside {KIND_INSERT, KIND_UPDATE, KIND_UPSERT,
                                             KIND_ERASE, KIND_LOOKUP}) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end

         // key search, one entry per cycle
         ST_SCAN: begin
            if (key_match) begin
               hit_in   = 1'b1;
               slot_in  = pend_idx_ff;
               pend_in  = 1'b0;
               state_in = ST_DECIDE;
               if (kind_ff == KIND_LOOKUP) begin
                  ok_in   = 1'b1;
                  fval_in = rd_value;
               end
            end else if (issue_ff < count_ff) begin
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               hit_in   = 1'b0;
               state_in = ST_DECIDE;
            end
         end

         // act on the search outcome
         ST_DECIDE: begin
            state_in = ST_REPLY;
            case (kind_ff)
               KIND_INSERT, KIND_UPDATE, KIND_UPSERT: begin
                  if (hit_ff && kind_ff != KIND_INSERT) begin
                     wr_en   = 1'b1;
                     wr_addr = slot_ff;
                     ok_in   = 1'b1;
                  end else if (!hit_ff && kind_ff != KIND_UPDATE && room) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     ok_in    = 1'b1;
                  end
               end
               KIND_ERASE: begin
                  if (hit_ff) begin
                     state_in = ST_ERASE_RD;
                  end
               end
               default: begin
               end
            endcase
         end

         // fetch the last pair
         ST_ERASE_RD: begin
            state_in = ST_ERASE_WR;
         end

         // move the last pair into the freed slot
         ST_ERASE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_key   = rd_key;
            wr_value = rd_value;
            count_in = last_idx;
            ok_in    = 1'b1;
            state_in = ST_REPLY;
         end

         // rank: fetch the next candidate
         ST_RANK_OUT: begin
            state_in = ST_RANK_CAND;
         end

         ST_RANK_CAND: begin
            cand_key_in = rd_key;
            cand_val_in = rd_value;
            issue_in    = '0;
            pend_in     = 1'b0;
            smaller_in  = '0;
            state_in    = ST_RANK_IN;
         end

         // rank: count stored keys below the candidate
         ST_RANK_IN: begin
            if (pend_ff && (cand_key_ff > rd_key)) begin
               smaller_in = smaller_ff + CW'(1);
            end
            if (issue_ff < count_ff) begin
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if (MW'(smaller_ff) == MW'(rank_ff)) begin
               ok_in    = 1'b1;
               fkey_in  = cand_key_ff;
               fval_in  = cand_val_ff;
               state_in = ST_REPLY;
            end else begin
               outer_in = outer_ff + CW'(1);
               if ((outer_ff + CW'(1)) < count_ff) begin
                  state_in = ST_RANK_OUT;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end

         // load the output register once it is free
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_key_in   = fkey_wide[KEY_PORT_W-1:0];
               rsp_val_in   = fval_wide[VALUE_PORT_W-1:0];
               rsp_cnt_in   = COUNT_OUT_W'(count_ff);
               rsp_empty_in = (count_ff == '0);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      rank_ff      <= rank_in;
      issue_ff     <= issue_in;
      pend_idx_ff  <= pend_idx_in;
      hit_ff       <= hit_in;
      slot_ff      <= slot_in;
      cand_key_ff  <= cand_key_in;
      cand_val_ff  <= cand_val_in;
      smaller_ff   <= smaller_in;
      outer_ff     <= outer_in;
      ok_ff        <= ok_in;
      fkey_ff      <= fkey_in;
      fval_ff      <= fval_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_empty_ff <= rsp_empty_in;
   end
endmodule
